/* src/tor_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tor_pkg;

  // Separator geometry: the configured word holds up to eight separator bytes.
  localparam int unsigned MAX_SEP_BYTES = 8;
  localparam int unsigned SEP_W         = 64;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned WIN_W         = MAX_SEP_BYTES * 8;

  // Position field in a queue entry covers the largest supported buffer.
  localparam int unsigned POS_W = 6;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LEN   = 4'd1;

  // Reset separator is a single dot.
  localparam logic [SEP_W-1:0] SEP_BYTES_RESET = 64'h2E;
  localparam logic [LEN_W-1:0] SEP_LEN_RESET   = 4'd1;

  typedef struct packed {
    logic [SEP_W-1:0] sep_bytes;
    logic [LEN_W-1:0] sep_len;
  } tor_cfg_t;

  // One classified input transaction handed from the front to the back.
  typedef struct packed {
    logic             has_byte;
    logic [7:0]       data;
    logic             mark;
    logic [POS_W-1:0] mark_pos;
    logic             is_end;
    logic             ovf;
  } tor_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FILT,
    B_SCAN,
    B_TOK,
    B_SEP,
    B_REV,
    B_EMPTY
  } tor_back_state_e;

  // Separator length in use, with long settings clamped.
  function automatic logic [LEN_W-1:0] sep_len_eff(input logic [LEN_W-1:0] len);
    sep_len_eff = (len > LEN_W'(MAX_SEP_BYTES)) ? LEN_W'(MAX_SEP_BYTES) : len;
  endfunction

  // Separator byte j, first byte in the low bits.
  function automatic logic [7:0] sep_byte(input logic [SEP_W-1:0] bytes,
                                          input logic [2:0]       j);
    sep_byte = bytes[{j, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

/* src/tor_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input string bytes.
interface tor_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_string;

  modport source (output valid, output data_byte, output last_byte,
                  output empty_string, input ready);
  modport sink   (input valid, input data_byte, input last_byte,
                  input empty_string, output ready);
endinterface

// Reordered string bytes.
interface tor_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_empty;
  logic       overflow;

  modport source (output valid, output out_byte, output out_last,
                  output out_empty, output overflow, input ready);
  modport sink   (input valid, input out_byte, input out_last,
                  input out_empty, input overflow, output ready);
endinterface

// Register writes.
interface tor_cfg_if import tor_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [SEP_W-1:0]     data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* src/tor_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tor_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/tor_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tor_queue import tor_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire tor_entry_t entry_i,
  output logic            room_o,
  output logic            valid_o,
  output tor_entry_t      entry_o,
  input  wire logic       pop_i
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  tor_entry_t    slot_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [NW-1:0] fill_q, fill_d;
  logic          do_push;
  logic          do_pop;

  assign room_o  = (fill_q != NW'(DEPTH));
  assign valid_o = (fill_q != '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && room_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill updates.
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + NW'(1);
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* src/tor_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tor_front import tor_pkg::*; #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tor_cfg_t cfg_i,
  tor_in_if.sink        in_if,
  input  wire logic     room_i,
  output logic          push_o,
  output tor_entry_t    entry_o
);

  localparam int unsigned CW = $clog2(MAX_BYTES + 1);

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    next_q, next_d;
  logic [WIN_W-1:0] win_q, win_d;
  logic             ovf_q, ovf_d;

  logic             accept;
  logic             take;
  logic             is_end;
  logic             store;
  logic [CW-1:0]    count_n;
  logic [WIN_W-1:0] win_n;
  logic             ovf_n;
  logic [LEN_W-1:0] len;
  logic [7:0]       cnt8;
  logic [7:0]       len8;
  logic [7:0]       start8;
  logic             hit;
  logic             mark;

  assign len    = sep_len_eff(cfg_i.sep_len);
  assign accept = in_if.valid && room_i;
  assign take   = !in_if.empty_string;
  assign is_end = in_if.empty_string || in_if.last_byte;

  assign in_if.ready = room_i;

  // Bytes past the buffer size are dropped and flagged.
  assign store   = take && (count_q < CW'(MAX_BYTES));
  assign count_n = store ? count_q + CW'(1) : count_q;
  assign win_n   = store ? {win_q[WIN_W-9:0], in_if.data_byte} : win_q;
  assign ovf_n   = ovf_q || (take && !store);

  assign cnt8   = 8'(count_n);
  assign len8   = 8'(len);
  assign start8 = cnt8 - len8;

  // Compare the newest bytes of the window against the separator.
  always_comb begin
    logic [LEN_W-1:0] kk;
    hit = 1'b1;
    kk  = '0;
    for (int j = 0; j < MAX_SEP_BYTES; j++) begin
      if (LEN_W'(j) < len) begin
        kk = len - LEN_W'(j) - LEN_W'(1);
        if (win_n[{kk[2:0], 3'b000} +: 8] != sep_byte(cfg_i.sep_bytes, 3'(j))) begin
          hit = 1'b0;
        end
      end
    end
  end

  // A match is kept only if it does not overlap the previous kept one.
  assign mark = store && (len != '0) && (cnt8 >= len8) && hit && (start8 >= 8'(next_q));

  // Classified transaction toward the back.
  always_comb begin
    push_o            = accept && (store || is_end);
    entry_o.has_byte  = store;
    entry_o.data      = in_if.data_byte;
    entry_o.mark      = mark;
    entry_o.mark_pos  = POS_W'(start8);
    entry_o.is_end    = is_end;
    entry_o.ovf       = ovf_n;
  end

  // String state; the end of a string returns it to its reset values.
  always_comb begin
    count_d = count_q;
    next_d  = next_q;
    win_d   = win_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (is_end) begin
        count_d = '0;
        next_d  = '0;
        win_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_n;
        win_d   = win_n;
        ovf_d   = ovf_n;
        if (mark) begin
          next_d = count_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      next_q  <= '0;
      win_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      next_q  <= next_d;
      win_q   <= win_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

/* src/tor_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tor_back import tor_pkg::*; #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire tor_cfg_t   cfg_i,
  input  wire logic       q_valid_i,
  input  wire tor_entry_t q_entry_i,
  output logic            q_ready_o,
  tor_out_if.source       out_if
);

  localparam int unsigned AW = $clog2(MAX_BYTES);
  localparam int unsigned CW = $clog2(MAX_BYTES + 1);

  tor_back_state_e state_q, state_d;

  logic [CW-1:0]      count_q, count_d;
  logic [MAX_BYTES-1:0] mark_q, mark_d;
  logic [MAX_BYTES:0] start_q, start_d;
  logic [CW-1:0]      prev_end_q, prev_end_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      cur_q, cur_d;
  logic [CW-1:0]      end_q, end_d;
  logic [CW-1:0]      tok_q, tok_d;
  logic [2:0]         sep_idx_q, sep_idx_d;
  logic [CW-1:0]      emit_q, emit_d;
  logic               ovf_q, ovf_d;

  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;
  logic               out_empty_q, out_empty_d;
  logic               out_ovf_q, out_ovf_d;
  logic               out_ram_q, out_ram_d;
  logic [7:0]         out_sep_q, out_sep_d;

  logic [LEN_W-1:0]   len;
  logic               pop;
  logic [CW-1:0]      cnt_in;
  logic               out_free;
  logic               filt_done;
  logic               sep_done;
  logic               issue_ram;
  logic               issue_sep;
  logic               issue_empty;
  logic [7:0]         sep_val;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;
  logic [7:0]         sum8;
  logic               keep;

  assign len       = sep_len_eff(cfg_i.sep_len);
  assign pop       = q_valid_i && (state_q == B_IDLE);
  assign q_ready_o = (state_q == B_IDLE);
  assign cnt_in    = count_q + CW'(q_entry_i.has_byte);
  assign out_free  = !out_valid_q || out_if.ready;
  assign filt_done = (ptr_q == count_q - CW'(1));
  assign sep_done  = ({1'b0, sep_idx_q} == len - LEN_W'(1));
  assign sep_val   = sep_byte(cfg_i.sep_bytes, sep_idx_q);

  // Filter pass: a mark is kept if it starts past the last kept separator
  // and the separator fits inside the string.
  assign sum8 = 8'(ptr_q) + 8'(len);
  assign keep = mark_q[ptr_q[AW-1:0]] && (ptr_q >= prev_end_q) && (sum8 <= 8'(count_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop && q_entry_i.is_end) begin
          if (cnt_in == '0) begin
            state_d = B_EMPTY;
          end else if (len == '0) begin
            state_d = B_REV;
          end else begin
            state_d = B_FILT;
          end
        end
      end
      B_FILT: begin
        if (filt_done) begin
          state_d = B_SCAN;
        end
      end
      B_SCAN: begin
        if (start_q[cur_q]) begin
          state_d = B_TOK;
        end
      end
      B_TOK: begin
        if (ptr_q == end_q) begin
          state_d = (tok_q == '0) ? B_IDLE : B_SEP;
        end
      end
      B_SEP: begin
        if (out_free && sep_done) begin
          state_d = B_SCAN;
        end
      end
      B_REV: begin
        if (ptr_q == '0) begin
          state_d = B_IDLE;
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    count_d     = count_q;
    mark_d      = mark_q;
    start_d     = start_q;
    prev_end_d  = prev_end_q;
    ptr_d       = ptr_q;
    cur_d       = cur_q;
    end_d       = end_q;
    tok_d       = tok_q;
    sep_idx_d   = sep_idx_q;
    emit_d      = emit_q;
    ovf_d       = ovf_q;
    issue_ram   = 1'b0;
    issue_sep   = 1'b0;
    issue_empty = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_raddr   = ptr_q[AW-1:0];

    unique case (state_q)
      B_IDLE: begin
        if (pop) begin
          ram_we  = q_entry_i.has_byte;
          count_d = cnt_in;
          if (q_entry_i.mark) begin
            mark_d[q_entry_i.mark_pos[AW-1:0]] = 1'b1;
          end
          if (q_entry_i.is_end) begin
            ovf_d      = q_entry_i.ovf;
            start_d[0] = 1'b1;
            prev_end_d = '0;
            emit_d     = '0;
            ptr_d      = (len == '0) ? cnt_in : '0;
          end
        end
      end
      B_FILT: begin
        if (keep) begin
          start_d[sum8[CW-1:0]] = 1'b1;
          prev_end_d            = sum8[CW-1:0];
        end
        ptr_d = ptr_q + CW'(1);
        if (filt_done) begin
          cur_d = count_q;
          end_d = count_q;
        end
      end
      B_SCAN: begin
        if (start_q[cur_q]) begin
          tok_d = cur_q;
          ptr_d = cur_q;
        end else begin
          cur_d = cur_q - CW'(1);
        end
      end
      B_TOK: begin
        if (ptr_q == end_q) begin
          sep_idx_d = '0;
          if (tok_q == '0) begin
            count_d = '0;
            mark_d  = '0;
            start_d = '0;
          end
        end else if (out_free) begin
          issue_ram = 1'b1;
          ptr_d     = ptr_q + CW'(1);
        end
      end
      B_SEP: begin
        if (out_free) begin
          issue_sep = 1'b1;
          if (sep_done) begin
            cur_d = tok_q - CW'(len);
            end_d = tok_q - CW'(len);
          end else begin
            sep_idx_d = sep_idx_q + 3'd1;
          end
        end
      end
      B_REV: begin
        ram_raddr = AW'(ptr_q - CW'(1));
        if (ptr_q == '0) begin
          count_d = '0;
          mark_d  = '0;
          start_d = '0;
        end else if (out_free) begin
          issue_ram = 1'b1;
          ptr_d     = ptr_q - CW'(1);
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          issue_empty = 1'b1;
          count_d     = '0;
          mark_d      = '0;
          start_d     = '0;
        end
      end
      default: ;
    endcase

    // Output stage; the RAM read register carries stored bytes.
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;
    out_ram_d   = out_ram_q;
    out_sep_d   = out_sep_q;
    if (issue_ram || issue_sep || issue_empty) begin
      out_valid_d = 1'b1;
      out_last_d  = issue_empty || (emit_q == count_q - CW'(1));
      out_empty_d = issue_empty;
      out_ovf_d   = ovf_q;
      out_ram_d   = issue_ram;
      out_sep_d   = issue_sep ? sep_val : 8'd0;
      emit_d      = emit_q + CW'(1);
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      count_q     <= '0;
      mark_q      <= '0;
      start_q     <= '0;
      prev_end_q  <= '0;
      ptr_q       <= '0;
      cur_q       <= '0;
      end_q       <= '0;
      tok_q       <= '0;
      sep_idx_q   <= '0;
      emit_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_ram_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mark_q      <= mark_d;
      start_q     <= start_d;
      prev_end_q  <= prev_end_d;
      ptr_q       <= ptr_d;
      cur_q       <= cur_d;
      end_q       <= end_d;
      tok_q       <= tok_d;
      sep_idx_q   <= sep_idx_d;
      emit_q      <= emit_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_ovf_q   <= out_ovf_d;
      out_ram_q   <= out_ram_d;
    end
  end

  // Separator byte payload.
  always_ff @(posedge clk_i) begin
    out_sep_q <= out_sep_d;
  end

  tor_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (q_entry_i.data),
    .re_i    (issue_ram),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_if.valid     = out_valid_q;
  assign out_if.out_byte  = out_ram_q ? ram_rdata : out_sep_q;
  assign out_if.out_last  = out_last_q;
  assign out_if.out_empty = out_empty_q;
  assign out_if.overflow  = out_ovf_q;

  // The store is never written while it is being read out.
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && issue_ram))
    else $error("byte store written during read-out");

  // A stored-byte result never goes past the string length.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_ram |-> (emit_q < count_q))
    else $error("more result bytes than stored bytes");

  // Returning to idle after a string leaves the string state clear.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE && state_d == B_IDLE) |=> (count_q == '0 && start_q == '0))
    else $error("string state not cleared after emission");

endmodule

`default_nettype wire

/* src/token_order_reverser_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Token order reverser.
// in_if carries one string byte per transaction; last_byte marks the final
// byte, empty_string ends a string without a byte. out_if returns the string
// with its separator-delimited tokens in reverse order, one byte per
// transaction, out_last on the final byte, out_empty for an empty result.
// cfg_if writes register 0 (separator bytes) and register 1 (length, zero
// means plain byte reversal); write it only while no string is in flight.
// Throughput: a byte is taken each cycle into a two-entry queue while the
// queue has room; the back stores one byte per cycle while idle. After the
// last byte of a string, the back runs a mark filter pass over the stored
// bytes, then backward token scans, and emits the tokens and separators;
// byte reversal only reads the stored bytes out backward. The single back
// state machine and the byte store read port set the pace, and the back
// takes no bytes of a new string until the current one has been emitted.
// Reset clears all string state and loads a single dot as separator.
// When the receiver stalls, the result stays on out_if and the front keeps
// taking bytes until the queue fills.
module token_order_reverser_core import tor_pkg::*; #(
  parameter int unsigned MAX_STRING_BYTES = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tor_in_if.sink    in_if,
  tor_out_if.source out_if,
  tor_cfg_if.sink   cfg_if
);

  tor_cfg_t   cfg_q, cfg_d;
  logic       push;
  logic       room;
  tor_entry_t push_entry;
  logic       q_valid;
  logic       q_ready;
  tor_entry_t q_entry;

  // Configuration registers.
  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      if (cfg_if.addr == REG_SEP_BYTES) begin
        cfg_d.sep_bytes = cfg_if.data;
      end else if (cfg_if.addr == REG_SEP_LEN) begin
        cfg_d.sep_len = cfg_if.data[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sep_bytes <= SEP_BYTES_RESET;
      cfg_q.sep_len   <= SEP_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tor_front #(
    .MAX_BYTES (MAX_STRING_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_if   (in_if),
    .room_i  (room),
    .push_o  (push),
    .entry_o (push_entry)
  );

  tor_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .room_o  (room),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_ready)
  );

  tor_back #(
    .MAX_BYTES (MAX_STRING_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_ready_o (q_ready),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

/* verif/token_order_reverser_core_tb.sv */
`timescale 1ns / 1ps

module token_order_reverser_core_tb import tor_pkg::*; ();

  localparam int unsigned BUF_BYTES     = 64;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES   = 3 * BUF_BYTES + 16;
  localparam int unsigned PHASE_ITEMS   = 8;

  // One reordered byte as it should appear on the result channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic       ovf;
  } reordered_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tor_in_if  in_if ();
  tor_out_if out_if ();
  tor_cfg_if cfg_if ();

  token_order_reverser_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Expected result bytes, oldest first.
  reordered_byte_t reordered_q[$];
  reordered_byte_t expected_head;
  bit              mismatch_seen = 1'b0;
  bit              steady = 1'b0;
  int unsigned     items_sent = 0;
  logic [7:0]      string_bytes[$];

  // Shadow of the block: configuration and the string being collected.
  logic [SEP_W-1:0] cfg_sep_bytes;
  logic [LEN_W-1:0] cfg_sep_len;
  logic [7:0]       held_bytes[BUF_BYTES];
  bit               sep_starts[BUF_BYTES];
  int               held_count;
  int               next_free_start;
  logic [63:0]      tail_window;
  bit               dropped_any;

  function automatic int used_sep_len();
    used_sep_len = (cfg_sep_len > MAX_SEP_BYTES) ? MAX_SEP_BYTES : int'(cfg_sep_len);
  endfunction

  function automatic void clear_held();
    foreach (sep_starts[i]) sep_starts[i] = 1'b0;
    held_count      = 0;
    next_free_start = 0;
    tail_window     = '0;
    dropped_any     = 1'b0;
  endfunction

  // Stores one byte and marks a separator that ends on it, leftmost first.
  function automatic void absorb_byte(input logic [7:0] b);
    int l;
    int start;
    bit hit;
    if (held_count >= BUF_BYTES) begin
      dropped_any = 1'b1;
      return;
    end
    held_bytes[held_count] = b;
    held_count++;
    tail_window = {tail_window[55:0], b};
    l = used_sep_len();
    if (l == 0 || held_count < l) return;
    start = held_count - l;
    hit = 1'b1;
    for (int j = 0; j < l; j++) begin
      if (tail_window[8*(l-1-j) +: 8] != cfg_sep_bytes[8*j +: 8]) hit = 1'b0;
    end
    if (hit && start >= next_free_start) begin
      sep_starts[start] = 1'b1;
      next_free_start = start + l;
    end
  endfunction

  // Emits the held string with its tokens in reverse order.
  function automatic void reorder_string();
    logic [7:0]      seq[$];
    int              starts[$];
    int              l;
    int              prev_end;
    int              s;
    int              e;
    reordered_byte_t rec;
    l = used_sep_len();
    if (held_count == 0) begin
      rec.data  = 8'h00;
      rec.last  = 1'b1;
      rec.empty = 1'b1;
      rec.ovf   = dropped_any;
      reordered_q.insert(reordered_q.size(), rec);
    end else begin
      if (l == 0) begin
        for (int p = held_count - 1; p >= 0; p--) seq.insert(seq.size(), held_bytes[p]);
      end else begin
        prev_end = 0;
        for (int p = 0; p < held_count; p++) begin
          if (sep_starts[p] && p >= prev_end && p + l <= held_count) begin
            starts.insert(starts.size(), p);
            prev_end = p + l;
          end
        end
        for (int t = starts.size(); t >= 0; t--) begin
          s = (t == 0) ? 0 : starts[t-1] + l;
          e = (t == starts.size()) ? held_count : starts[t];
          if (t != starts.size()) begin
            for (int k = 0; k < l; k++) seq.insert(seq.size(), cfg_sep_bytes[8*k +: 8]);
          end
          for (int k = s; k < e; k++) seq.insert(seq.size(), held_bytes[k]);
        end
      end
      foreach (seq[i]) begin
        rec.data  = seq[i];
        rec.last  = (i == seq.size() - 1);
        rec.empty = 1'b0;
        rec.ovf   = dropped_any;
        reordered_q.insert(reordered_q.size(), rec);
      end
    end
    clear_held();
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  // Each result transaction is compared with the oldest expected byte.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (reordered_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %02h last %0b empty %0b ovf %0b",
                 $time, out_if.out_byte, out_if.out_last, out_if.out_empty, out_if.overflow);
        mismatch_seen = 1'b1;
      end else begin
        expected_head = reordered_q.pop_front();
        check_field("out_byte", expected_head.data, out_if.out_byte);
        check_field("out_last", 8'(expected_head.last), 8'(out_if.out_last));
        check_field("out_empty", 8'(expected_head.empty), 8'(out_if.out_empty));
        check_field("overflow", 8'(expected_head.ovf), 8'(out_if.overflow));
      end
    end
  end

  // Receiver side: a random stall before each result transaction.
  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // Sends one input transaction after a random gap; valid stays high on return.
  task automatic send_item(input logic [7:0] data, input logic last, input logic empty);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= data;
    in_if.last_byte    <= last;
    in_if.empty_string <= empty;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (!empty) absorb_byte(data);
    if (empty || last) reorder_string();
  endtask

  // Sends string_bytes, ended by the last mark or by an empty-string mark.
  task automatic send_buffered(input bit mark_end);
    foreach (string_bytes[i]) begin
      send_item(string_bytes[i], (i == string_bytes.size() - 1) && !mark_end, 1'b0);
    end
    if (mark_end || string_bytes.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  task automatic send_text(input string s, input bit mark_end);
    string_bytes.delete();
    for (int i = 0; i < s.len(); i++) string_bytes.insert(string_bytes.size(), s[i]);
    send_buffered(mark_end);
  endtask

  // Random content rich in whole and broken separators.
  task automatic fill_random(input int n);
    int l;
    int cut;
    l = used_sep_len();
    string_bytes.delete();
    while (string_bytes.size() < n) begin
      if (l > 0 && $urandom_range(0, 2) == 0) begin
        cut = ($urandom_range(0, 3) == 0) ? l - 1 : l;
        for (int j = 0; j < cut; j++) begin
          string_bytes.insert(string_bytes.size(), cfg_sep_bytes[8*j +: 8]);
        end
      end else if (l > 0 && $urandom_range(0, 1) == 1) begin
        string_bytes.insert(string_bytes.size(),
                            cfg_sep_bytes[8*$urandom_range(0, l - 1) +: 8]);
      end else begin
        string_bytes.insert(string_bytes.size(), 8'($urandom_range(0, 255)));
      end
    end
    while (string_bytes.size() > n) void'(string_bytes.pop_back());
  endtask

  // Stops input and waits until the block has nothing left to return.
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (reordered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEP_W-1:0] value);
    settle_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_SEP_BYTES) cfg_sep_bytes = value;
    else if (idx == REG_SEP_LEN) cfg_sep_len = value[LEN_W-1:0];
  endtask

  task automatic set_separator(input logic [SEP_W-1:0] bytes, input logic [SEP_W-1:0] len);
    write_reg(REG_SEP_BYTES, bytes);
    write_reg(REG_SEP_LEN, len);
  endtask

  // Reset separator: leading, trailing and empty tokens, empty strings, byte extremes.
  task automatic test_default_separator();
    send_text(".ab..c.", 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_text("xy", 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  // A run of separator bytes matches leftmost without overlap.
  task automatic test_overlapping_matches();
    set_separator(64'h6161, 64'd2);
    send_text("xaaay", 1'b0);
  endtask

  task automatic test_byte_reversal();
    set_separator('1, 64'd0);
    send_text("abc", 1'b1);
  endtask

  // Bytes past the buffer are dropped and flagged.
  task automatic test_buffer_overflow();
    set_separator(64'h2E, 64'd1);
    fill_random(BUF_BYTES + 1);
    send_buffered(1'b0);
  endtask

  // Random strings under a series of separator settings.
  task automatic test_random_settings();
    logic [SEP_W-1:0] word;
    logic [SEP_W-1:0] len_word;
    int unsigned      phase_start;
    int               r;
    int               n;
    for (int ph = 0; ph < 7; ph++) begin
      word = {$urandom, $urandom};
      for (int j = 0; j < 8; j++) begin
        if (ph >= 2 && $urandom_range(0, 3) != 0) begin
          word[8*j +: 8] = 8'(8'h61 + $urandom_range(0, 1));
        end
      end
      len_word = {$urandom, $urandom};
      case (ph)
        0: len_word[3:0] = 4'd1;
        1: begin
          word = '0;
          len_word[3:0] = 4'd1;
        end
        2: len_word[3:0] = 4'd2;
        3: len_word[3:0] = 4'd8;
        4: len_word[3:0] = 4'($urandom_range(9, 15));
        5: len_word[3:0] = 4'd0;
        default: len_word[3:0] = 4'd3;
      endcase
      set_separator(word, len_word);
      steady = (ph == 3);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(0, 15);
        if (r == 0) n = 0;
        else if (r < 14) n = $urandom_range(1, 10);
        else if (r == 14) n = $urandom_range(11, 40);
        else n = $urandom_range(60, 66);
        fill_random(n);
        send_buffered($urandom_range(0, 3) == 0);
      end
      steady = 1'b0;
    end
  endtask

  initial begin : stimulus
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= 8'h00;
    in_if.last_byte    <= 1'b0;
    in_if.empty_string <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.addr        <= REG_SEP_BYTES;
    cfg_if.data        <= '0;
    cfg_sep_bytes = SEP_BYTES_RESET;
    cfg_sep_len   = SEP_LEN_RESET;
    clear_held();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_separator();
    test_overlapping_matches();
    test_byte_reversal();
    test_buffer_overflow();
    test_random_settings();

    // Drain, then allow time for any stray result to show up.
    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (!mismatch_seen && reordered_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* token_order_reverser_core.f */
src/tor_pkg.sv
src/tor_if.sv
src/tor_ram.sv
src/tor_queue.sv
src/tor_front.sv
src/tor_back.sv
src/token_order_reverser_core.sv
verif/token_order_reverser_core_tb.sv
